FILE: src/efc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package efc_pkg;

  // Fixed-point word width of every coordinate and orbit value.
  localparam int QW = 32;

  // Configuration register indexes.
  localparam logic [2:0] REG_X_ORIGIN = 3'd0;
  localparam logic [2:0] REG_Y_ORIGIN = 3'd1;
  localparam logic [2:0] REG_X_STEP   = 3'd2;
  localparam logic [2:0] REG_Y_STEP   = 3'd3;
  localparam logic [2:0] REG_MAX_ITER = 3'd4;
  localparam logic [2:0] REG_ESC_LIM  = 3'd5;

  typedef struct packed {
    logic signed [31:0] x_origin;
    logic signed [31:0] y_origin;
    logic [30:0]        x_step;
    logic [30:0]        y_step;
    logic [15:0]        max_iterations;
    logic [6:0]         escape_limit;
  } cfg_t;

  // Clamp a wide signed value to the 32-bit two's complement range.
  function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
    logic [32:0] hi;
    logic signed [31:0] res;
    hi = v[63:31];
    if (hi == '0 || hi == '1) begin
      res = v[31:0];
    end else if (v[63]) begin
      res = 32'sh8000_0000;
    end else begin
      res = 32'sh7FFF_FFFF;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: src/efc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module efc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW:0]      cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt_r == (AW+1)'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: src/efc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module efc_front #(
  parameter int PIXEL_INDEX_BITS = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire efc_pkg::cfg_t               cfg,
  input  wire logic                        in_push,
  output logic                             in_full,
  input  wire logic [PIXEL_INDEX_BITS-1:0] in_col,
  input  wire logic [PIXEL_INDEX_BITS-1:0] in_row,
  output logic                             q_push,
  input  wire logic                        q_full,
  output logic [PIXEL_INDEX_BITS-1:0]      q_col,
  output logic [PIXEL_INDEX_BITS-1:0]      q_row,
  output logic signed [31:0]               q_cre,
  output logic signed [31:0]               q_cim
);

  localparam int PW = PIXEL_INDEX_BITS + 31;

  logic                        s0_v_r;
  logic [PIXEL_INDEX_BITS-1:0] s0_col_r;
  logic [PIXEL_INDEX_BITS-1:0] s0_row_r;
  logic [PW-1:0]               s0_px_r;
  logic [PW-1:0]               s0_py_r;
  logic                        s1_v_r;
  logic [PIXEL_INDEX_BITS-1:0] s1_col_r;
  logic [PIXEL_INDEX_BITS-1:0] s1_row_r;
  logic signed [31:0]          s1_cre_r;
  logic signed [31:0]          s1_cim_r;
  logic signed [31:0]          cre_nxt;
  logic signed [31:0]          cim_nxt;
  logic                        s0_adv;
  logic                        s1_adv;

  assign s1_adv  = !s1_v_r || !q_full;
  assign s0_adv  = !s0_v_r || s1_adv;
  assign in_full = !s0_adv;

  // The products are unsigned and the origin is signed, so the sum is done in 64 bits.
  assign cre_nxt = efc_pkg::sat_q(64'(cfg.x_origin) + $signed(64'(s0_px_r)));
  assign cim_nxt = efc_pkg::sat_q(64'(cfg.y_origin) + $signed(64'(s0_py_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      if (s0_adv) begin
        s0_v_r <= in_push;
      end
      if (s1_adv) begin
        s1_v_r <= s0_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv) begin
      s0_col_r <= in_col;
      s0_row_r <= in_row;
      s0_px_r  <= PW'(in_col) * PW'(cfg.x_step);
      s0_py_r  <= PW'(in_row) * PW'(cfg.y_step);
    end
    if (s1_adv) begin
      s1_col_r <= s0_col_r;
      s1_row_r <= s0_row_r;
      s1_cre_r <= cre_nxt;
      s1_cim_r <= cim_nxt;
    end
  end

  assign q_push = s1_v_r;
  assign q_col  = s1_col_r;
  assign q_row  = s1_row_r;
  assign q_cre  = s1_cre_r;
  assign q_cim  = s1_cim_r;

endmodule

`default_nettype wire

FILE: src/efc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module efc_back #(
  parameter int PIXEL_INDEX_BITS = 12,
  parameter int FRACTION_BITS    = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire efc_pkg::cfg_t               cfg,
  input  wire logic                        q_empty,
  output logic                             q_pop,
  input  wire logic [PIXEL_INDEX_BITS-1:0] q_col,
  input  wire logic [PIXEL_INDEX_BITS-1:0] q_row,
  input  wire logic signed [31:0]          q_cre,
  input  wire logic signed [31:0]          q_cim,
  output logic                             r_push,
  input  wire logic                        r_full,
  output logic [PIXEL_INDEX_BITS-1:0]      r_col,
  output logic [PIXEL_INDEX_BITS-1:0]      r_row,
  output logic [15:0]                      r_count
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]                  state_r;
  logic [1:0]                  state_nxt;
  logic [PIXEL_INDEX_BITS-1:0] col_r;
  logic [PIXEL_INDEX_BITS-1:0] row_r;
  logic signed [31:0]          cre_r;
  logic signed [31:0]          cim_r;
  logic signed [31:0]          a_r;
  logic signed [31:0]          b_r;
  logic [15:0]                 n_r;
  logic signed [31:0]          a_nxt;
  logic signed [31:0]          b_nxt;
  logic [15:0]                 n_nxt;
  logic signed [63:0]          paa;
  logic signed [63:0]          pbb;
  logic signed [63:0]          pab;
  logic signed [63:0]          aa;
  logic signed [63:0]          bb;
  logic signed [63:0]          ab2;
  logic signed [63:0]          mag;
  logic signed [63:0]          limit;
  logic                        go;
  logic                        load;

  // One orbit step per cycle from the registered z while the engine is in ST_RUN.
  assign paa   = a_r * a_r;
  assign pbb   = b_r * b_r;
  assign pab   = a_r * b_r;
  assign aa    = paa >>> FRACTION_BITS;
  assign bb    = pbb >>> FRACTION_BITS;
  assign ab2   = pab >>> (FRACTION_BITS - 1);
  assign mag   = aa + bb;
  assign limit = $signed(64'(cfg.escape_limit) << FRACTION_BITS);
  assign a_nxt = efc_pkg::sat_q(aa - bb + 64'(cre_r));
  assign b_nxt = efc_pkg::sat_q(ab2 + 64'(cim_r));
  assign n_nxt = n_r + 16'd1;
  // The escape test uses the magnitude of z before this step's update.
  assign go    = (n_nxt < cfg.max_iterations) && (mag < limit);

  assign load  = (state_r == ST_IDLE) && !q_empty;
  assign q_pop = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!go) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!r_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      col_r <= q_col;
      row_r <= q_row;
      cre_r <= q_cre;
      cim_r <= q_cim;
      a_r   <= q_cre;
      b_r   <= q_cim;
      n_r   <= '0;
    end else if (state_r == ST_RUN) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      n_r <= n_nxt;
    end
  end

  assign r_push  = (state_r == ST_PUSH);
  assign r_col   = col_r;
  assign r_row   = row_r;
  assign r_count = n_r;

endmodule

`default_nettype wire

FILE: src/escape_time_fractal_counter.sv
// Channel | Direction | Handshake                 | Payload
// in      | request   | in_push / in_full         | in_col, in_row
// out     | result    | out_pop / out_empty       | out_col, out_row, out_count
// cfg     | write     | cfg_valid / cfg_ready (1) | cfg_index, cfg_data
//
// The iteration engine runs one orbit step per cycle on three 32x32 multipliers; the point
// is formed in a two-stage front end ahead of it.
// Pixels are iterated one at a time, so throughput is set by that loop.
// Reset is synchronous, active low, and restores the default view and limits.
// A two-entry queue between the front end and the engine, and another on the result side,
// let either side stall without losing a request or a result.
`timescale 1ns / 1ps
`default_nettype none

module escape_time_fractal_counter #(
  parameter int PIXEL_INDEX_BITS = 12,
  parameter int FRACTION_BITS    = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  output logic                             in_full,
  input  wire logic [PIXEL_INDEX_BITS-1:0] in_col,
  input  wire logic [PIXEL_INDEX_BITS-1:0] in_row,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output logic [PIXEL_INDEX_BITS-1:0]      out_col,
  output logic [PIXEL_INDEX_BITS-1:0]      out_row,
  output logic [15:0]                      out_count,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [2:0]                  cfg_index,
  input  wire logic [31:0]                 cfg_data
);

  localparam int MW = 2 * PIXEL_INDEX_BITS + 64;
  localparam int RW = 2 * PIXEL_INDEX_BITS + 16;

  localparam logic signed [31:0] X_ORIGIN_RST = -(32'sd2 <<< FRACTION_BITS);
  localparam logic signed [31:0] Y_ORIGIN_RST = -(32'sd1 <<< FRACTION_BITS);
  localparam logic [30:0]        STEP_RST     = 31'd1 << (FRACTION_BITS - 8);

  efc_pkg::cfg_t cfg_r;

  logic                        f_push;
  logic                        mid_full;
  logic [PIXEL_INDEX_BITS-1:0] f_col;
  logic [PIXEL_INDEX_BITS-1:0] f_row;
  logic signed [31:0]          f_cre;
  logic signed [31:0]          f_cim;
  logic                        mid_empty;
  logic                        mid_pop;
  logic [MW-1:0]               mid_data;
  logic                        b_push;
  logic                        res_full;
  logic [PIXEL_INDEX_BITS-1:0] b_col;
  logic [PIXEL_INDEX_BITS-1:0] b_row;
  logic [15:0]                 b_count;
  logic [RW-1:0]               res_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_origin       <= X_ORIGIN_RST;
      cfg_r.y_origin       <= Y_ORIGIN_RST;
      cfg_r.x_step         <= STEP_RST;
      cfg_r.y_step         <= STEP_RST;
      cfg_r.max_iterations <= 16'd64;
      cfg_r.escape_limit   <= 7'd32;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        efc_pkg::REG_X_ORIGIN: cfg_r.x_origin       <= cfg_data;
        efc_pkg::REG_Y_ORIGIN: cfg_r.y_origin       <= cfg_data;
        efc_pkg::REG_X_STEP:   cfg_r.x_step         <= cfg_data[30:0];
        efc_pkg::REG_Y_STEP:   cfg_r.y_step         <= cfg_data[30:0];
        efc_pkg::REG_MAX_ITER: cfg_r.max_iterations <= cfg_data[15:0];
        efc_pkg::REG_ESC_LIM:  cfg_r.escape_limit   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  efc_front #(
    .PIXEL_INDEX_BITS(PIXEL_INDEX_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_full (in_full),
    .in_col  (in_col),
    .in_row  (in_row),
    .q_push  (f_push),
    .q_full  (mid_full),
    .q_col   (f_col),
    .q_row   (f_row),
    .q_cre   (f_cre),
    .q_cim   (f_cim)
  );

  efc_queue #(
    .WIDTH(MW),
    .DEPTH(2)
  ) u_mid_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data ({f_col, f_row, f_cre, f_cim}),
    .full      (mid_full),
    .pop       (mid_pop),
    .empty     (mid_empty),
    .pop_data  (mid_data)
  );

  efc_back #(
    .PIXEL_INDEX_BITS(PIXEL_INDEX_BITS),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (mid_empty),
    .q_pop   (mid_pop),
    .q_col   (mid_data[MW-1 -: PIXEL_INDEX_BITS]),
    .q_row   (mid_data[63 + PIXEL_INDEX_BITS -: PIXEL_INDEX_BITS]),
    .q_cre   (mid_data[63:32]),
    .q_cim   (mid_data[31:0]),
    .r_push  (b_push),
    .r_full  (res_full),
    .r_col   (b_col),
    .r_row   (b_row),
    .r_count (b_count)
  );

  efc_queue #(
    .WIDTH(RW),
    .DEPTH(2)
  ) u_res_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (b_push),
    .push_data ({b_col, b_row, b_count}),
    .full      (res_full),
    .pop       (out_pop),
    .empty     (out_empty),
    .pop_data  (res_data)
  );

  assign out_col   = res_data[RW-1 -: PIXEL_INDEX_BITS];
  assign out_row   = res_data[15 + PIXEL_INDEX_BITS -: PIXEL_INDEX_BITS];
  assign out_count = res_data[15:0];

`ifndef SYNTHESIS
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    b_push && res_full |=> b_push && $stable(b_count))
    else $error("result held back while the result queue was full was not kept");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_count != 16'd0)
    else $error("result with zero iteration count");

  a_pop_then_push: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop && !mid_empty |=> !b_push)
    else $error("result pushed right after a new point was loaded");
`endif

endmodule

`default_nettype wire
